/* rtl/si2dec_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the signed integer to decimal text core.
// No dependencies.
package si2dec_pkg;

	// ASCII codes, six bits wide as carried on the output
	localparam logic [5:0] CHAR_ZERO  = 6'd48;
	localparam logic [5:0] CHAR_MINUS = 6'd45;

	// Magnitude bits folded into BCD per conversion cycle
	localparam int BITS_PER_STEP = 4;

	// log10(2) as a ratio, used to size the digit buffer
	localparam int LOG10_2_NUM = 301;
	localparam int LOG10_2_DEN = 1000;

	typedef enum logic [1:0] {
		FE_IDLE,
		FE_CONV,
		FE_PUSH
	} fe_state_t;

	typedef enum logic [1:0] {
		BE_IDLE,
		BE_SIGN,
		BE_DIGIT
	} be_state_t;

endpackage

/* rtl/si2dec_front.sv */
`timescale 1ns / 1ps
// Front end: takes a signed word, forms sign and magnitude, converts the
// magnitude to BCD (double dabble, four bits a cycle). Uses si2dec_pkg.
module si2dec_front #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [VALUE_WIDTH-1:0]     value,
	output logic                              q_valid,
	input  logic                              q_stall,
	output logic                              q_neg,
	output logic [$clog2((VALUE_WIDTH*si2dec_pkg::LOG10_2_NUM)/si2dec_pkg::LOG10_2_DEN
		+ 1)-1:0]                             q_top,
	output logic [4*((VALUE_WIDTH*si2dec_pkg::LOG10_2_NUM)/si2dec_pkg::LOG10_2_DEN
		+ 1)-1:0]                             q_bcd
);

	localparam int NDIG  = (VALUE_WIDTH*si2dec_pkg::LOG10_2_NUM)/si2dec_pkg::LOG10_2_DEN + 1;
	localparam int IDX_W = $clog2(NDIG);
	localparam int BCD_W = 4*NDIG;
	localparam int BPS   = si2dec_pkg::BITS_PER_STEP;
	localparam int STEPS = (VALUE_WIDTH + BPS - 1) / BPS;
	localparam int PAD_W = STEPS*BPS;
	localparam int CNT_W = $clog2(STEPS + 1);

	si2dec_pkg::fe_state_t state_q, state_nx;

	logic [PAD_W-1:0]       bin_q;
	logic [BCD_W-1:0]       bcd_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   neg_q;
	logic [VALUE_WIDTH-1:0] mag;
	logic [PAD_W-1:0]       bin_nx;
	logic [BCD_W-1:0]       bcd_nx;
	logic [IDX_W-1:0]       top;
	logic                   accept;

	assign accept = in_valid && !in_stall;
	assign mag = value[VALUE_WIDTH-1] ? (~value + 1'b1) : value;

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			si2dec_pkg::FE_IDLE: if (in_valid) state_nx = si2dec_pkg::FE_CONV;
			si2dec_pkg::FE_CONV: if (cnt_q == CNT_W'(STEPS-1)) state_nx = si2dec_pkg::FE_PUSH;
			si2dec_pkg::FE_PUSH: if (!q_stall) state_nx = si2dec_pkg::FE_IDLE;
			default: state_nx = si2dec_pkg::FE_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_stall = 1'b1;
		q_valid  = 1'b0;
		case (state_q)
			si2dec_pkg::FE_IDLE: in_stall = 1'b0;
			si2dec_pkg::FE_CONV: in_stall = 1'b1;
			si2dec_pkg::FE_PUSH: q_valid  = 1'b1;
			default: in_stall = 1'b1;
		endcase
	end

	// four double-dabble steps: add 3 to each digit >= 5, then shift
	always_comb begin
		bcd_nx = bcd_q;
		bin_nx = bin_q;
		for (int k = 0; k < BPS; k++) begin
			for (int d = 0; d < NDIG; d++) begin
				if (bcd_nx[d*4 +: 4] >= 4'd5) bcd_nx[d*4 +: 4] = bcd_nx[d*4 +: 4] + 4'd3;
			end
			bcd_nx = {bcd_nx[BCD_W-2:0], bin_nx[PAD_W-1]};
			bin_nx = {bin_nx[PAD_W-2:0], 1'b0};
		end
	end

	// index of the most significant nonzero digit (0 for zero)
	always_comb begin
		top = '0;
		for (int i = 0; i < NDIG; i++) begin
			if (bcd_q[i*4 +: 4] != 4'd0) top = IDX_W'(i);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= si2dec_pkg::FE_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			bin_q <= PAD_W'(mag);
			bcd_q <= '0;
			cnt_q <= '0;
			neg_q <= value[VALUE_WIDTH-1];
		end else if (state_q == si2dec_pkg::FE_CONV) begin
			bin_q <= bin_nx;
			bcd_q <= bcd_nx;
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	assign q_neg = neg_q;
	assign q_top = top;
	assign q_bcd = bcd_q;

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == si2dec_pkg::FE_CONV)
		else $error("front: accepted word did not start conversion");

endmodule

/* rtl/si2dec_queue.sv */
`timescale 1ns / 1ps
// Two-entry queue between front and back ends.
// No package dependencies.
module si2dec_queue #(
	parameter int DATA_W = 45
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_valid,
	output logic              wr_stall,
	input  logic [DATA_W-1:0] wr_data,
	output logic              rd_valid,
	input  logic              rd_stall,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem_q [2];
	logic              wptr_q;
	logic              rptr_q;
	logic [1:0]        count_q;
	logic              push;
	logic              pop;

	assign wr_stall = (count_q == 2'd2);
	assign rd_valid = (count_q != 2'd0);
	assign rd_data  = mem_q[rptr_q];
	assign push     = wr_valid && !wr_stall;
	assign pop      = rd_valid && !rd_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) wptr_q <= ~wptr_q;
			if (pop) rptr_q <= ~rptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wptr_q] <= wr_data;
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("queue: occupancy overflow");

endmodule

/* rtl/si2dec_back.sv */
`timescale 1ns / 1ps
// Back end: pops a converted number, emits sign if negative, then digits
// one word a cycle unless stalled, via an output register. Uses si2dec_pkg.
module si2dec_back #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              q_valid,
	output logic                              q_stall,
	input  logic                              q_neg,
	input  logic [$clog2((VALUE_WIDTH*si2dec_pkg::LOG10_2_NUM)/si2dec_pkg::LOG10_2_DEN
		+ 1)-1:0]                             q_top,
	input  logic [4*((VALUE_WIDTH*si2dec_pkg::LOG10_2_NUM)/si2dec_pkg::LOG10_2_DEN
		+ 1)-1:0]                             q_bcd,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [5:0]                        char_code,
	output logic                              last_char
);

	localparam int NDIG  = (VALUE_WIDTH*si2dec_pkg::LOG10_2_NUM)/si2dec_pkg::LOG10_2_DEN + 1;
	localparam int IDX_W = $clog2(NDIG);
	localparam int BCD_W = 4*NDIG;

	si2dec_pkg::be_state_t state_q, state_nx;

	logic [BCD_W-1:0] bcd_q;
	logic [IDX_W-1:0] idx_q;
	logic             out_valid_q;
	logic [5:0]       char_q;
	logic             last_q;
	logic             slot_free;
	logic             pop;
	logic             emit_sign;
	logic             emit_digit;
	logic [3:0]       digit;

	assign slot_free = !out_valid_q || !out_stall;
	assign digit     = bcd_q[idx_q*4 +: 4];

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			si2dec_pkg::BE_IDLE:
				if (q_valid) state_nx = q_neg ? si2dec_pkg::BE_SIGN : si2dec_pkg::BE_DIGIT;
			si2dec_pkg::BE_SIGN:
				if (slot_free) state_nx = si2dec_pkg::BE_DIGIT;
			si2dec_pkg::BE_DIGIT:
				if (slot_free && idx_q == '0) state_nx = si2dec_pkg::BE_IDLE;
			default: state_nx = si2dec_pkg::BE_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		q_stall    = 1'b1;
		emit_sign  = 1'b0;
		emit_digit = 1'b0;
		case (state_q)
			si2dec_pkg::BE_IDLE:  q_stall    = 1'b0;
			si2dec_pkg::BE_SIGN:  emit_sign  = slot_free;
			si2dec_pkg::BE_DIGIT: emit_digit = slot_free;
			default: q_stall = 1'b1;
		endcase
	end

	assign pop = q_valid && !q_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= si2dec_pkg::BE_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (emit_sign || emit_digit) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			bcd_q <= q_bcd;
			idx_q <= q_top;
		end else if (emit_digit && idx_q != '0) begin
			idx_q <= idx_q - IDX_W'(1);
		end
		if (emit_sign) begin
			char_q <= si2dec_pkg::CHAR_MINUS;
			last_q <= 1'b0;
		end else if (emit_digit) begin
			char_q <= si2dec_pkg::CHAR_ZERO + {2'b00, digit};
			last_q <= (idx_q == '0);
		end
	end

	assign out_valid = out_valid_q;
	assign char_code = char_q;
	assign last_char = last_q;

	a_sign_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && char_q == si2dec_pkg::CHAR_MINUS |-> !last_q)
		else $error("back: minus sign flagged as last character");

	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && char_q != si2dec_pkg::CHAR_MINUS |->
		char_q >= si2dec_pkg::CHAR_ZERO && char_q <= si2dec_pkg::CHAR_ZERO + 6'd9)
		else $error("back: emitted code is not a digit");

	a_pop_starts_run: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> state_q != si2dec_pkg::BE_IDLE)
		else $error("back: popped entry did not start a run");

endmodule

/* rtl/signed_int_to_decimal_chars_core.sv */
`timescale 1ns / 1ps
// Top level of the signed integer to decimal ASCII converter.
// Instantiates si2dec_front, si2dec_queue and si2dec_back; uses si2dec_pkg.
//
// Each word on the input channel is a VALUE_WIDTH-bit two's complement
// integer; the output channel returns its decimal text, one ASCII code per
// word, most significant character first: a '-' (45) for negative values,
// then the digits '0'..'9' (48..57) with leading zeros suppressed, zero
// giving a single '0'. The most negative value prints in full. last_char is
// high on the final character of each number. The front end takes a word
// when idle and runs it through its double-dabble converter (four
// magnitude bits per cycle), then hands it off, and takes no new word
// until the handoff is done. The back end emits one character per cycle
// while the output is not stalled, and picks up the next entry only after
// the last character of the current number has been emitted.
// A two-entry queue between the two lets each side stall on its own, so the
// sustained rate is the slower of the two for the number mix at hand.
// There are no configuration registers and nothing is kept between numbers.
module signed_int_to_decimal_chars_core #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [VALUE_WIDTH-1:0] value,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [5:0]                    char_code,
	output logic                          last_char
);

	// digit buffer sizing, same formula as in front and back ends
	localparam int NDIG   = (VALUE_WIDTH*si2dec_pkg::LOG10_2_NUM)/si2dec_pkg::LOG10_2_DEN + 1;
	localparam int IDX_W  = $clog2(NDIG);
	localparam int BCD_W  = 4*NDIG;
	localparam int DATA_W = 1 + IDX_W + BCD_W;

	// front -> queue
	logic             f_valid;
	logic             f_stall;
	logic             f_neg;
	logic [IDX_W-1:0] f_top;
	logic [BCD_W-1:0] f_bcd;

	// queue -> back
	logic              b_valid;
	logic              b_stall;
	logic [DATA_W-1:0] b_data;

	si2dec_front #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.value    (value),
		.q_valid  (f_valid),
		.q_stall  (f_stall),
		.q_neg    (f_neg),
		.q_top    (f_top),
		.q_bcd    (f_bcd)
	);

	// entry layout: sign, index of leading digit, BCD digits
	si2dec_queue #(
		.DATA_W(DATA_W)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (f_valid),
		.wr_stall (f_stall),
		.wr_data  ({f_neg, f_top, f_bcd}),
		.rd_valid (b_valid),
		.rd_stall (b_stall),
		.rd_data  (b_data)
	);

	si2dec_back #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (b_valid),
		.q_stall   (b_stall),
		.q_neg     (b_data[DATA_W-1]),
		.q_top     (b_data[BCD_W +: IDX_W]),
		.q_bcd     (b_data[BCD_W-1:0]),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.char_code (char_code),
		.last_char (last_char)
	);

endmodule
